[rtl/core/envelope_distance_score_core_assert.svh]
// Assertion macros shared by the envelope distance score checker.
// No dependencies.
`ifndef ENVELOPE_DISTANCE_SCORE_CORE_ASSERT_SVH
`define ENVELOPE_DISTANCE_SCORE_CORE_ASSERT_SVH

// Assert an implication on the next clock edge, disabled during reset.
`define EDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Assert an implication in the same cycle, disabled during reset.
`define EDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/eds_pkg.sv]
// Shared types and constants for the envelope distance score block.
// No dependencies.
package eds_pkg;

    localparam int NUM_VARS_DEF = 16;
    localparam int IDX_W        = 4;
    localparam int VAL_W        = 16;
    localparam int SPR_W        = 17;
    localparam int DIST_W       = 19;
    localparam int SUM_W        = 36;
    localparam int ROOT_W       = 18;
    localparam int QUO_W        = 36;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] var_index;
        logic [VAL_W-1:0] sample_value;
        logic [SPR_W-1:0] spread_in;
        logic [VAL_W-1:0] lower_in;
        logic [VAL_W-1:0] upper_in;
        logic             last_element;
    } t_in_req;

    typedef struct packed {
        logic [VAL_W-1:0] presence_score;
        logic             inside_envelope;
    } t_out_req;

    // Completed vector handed from the front part to the back part.
    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic             outside;
    } t_vec_req;

endpackage

[rtl/core/eds_front.sv]
// Front part: table loads and per-element accumulation; emits one vector
// request per last element. Depends on eds_pkg.
module eds_front import eds_pkg::*; #(
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_data,
    output logic     o_vec_valid,
    input  logic     i_vec_stall,
    output t_vec_req o_vec
);

    logic [VAL_W-1:0] r_mean  [2**IDX_W];
    logic [SPR_W-1:0] r_spread[2**IDX_W];
    logic [VAL_W-1:0] r_lower [2**IDX_W];
    logic [VAL_W-1:0] r_upper [2**IDX_W];

    // stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_s1_in_range;
    logic [VAL_W-1:0] r_s1_mag;
    logic             r_s1_out;

    logic [SUM_W-1:0] r_sum;
    logic             r_outside;
    logic             r_vec_valid;
    t_vec_req         r_vec;

    logic             accept;
    logic             idx_ok;
    logic [VAL_W-1:0] m_rd;
    logic [VAL_W-1:0] mag;
    logic [SUM_W:0]   n_sum;
    logic [SUM_W-1:0] sum_sat;
    logic             n_out;
    logic             s1_stall;
    logic             vec_load;

    // hold stage 1 only when a finished vector cannot move on
    assign s1_stall = r_s1_valid && r_s1_last && r_vec_valid && i_vec_stall;
    assign vec_load = !s1_stall && r_s1_valid && r_s1_last;
    assign o_stall  = s1_stall;
    assign accept   = i_valid && !o_stall;
    assign idx_ok   = 32'(i_data.var_index) < NUM_VARS;
    assign m_rd     = idx_ok ? r_mean[i_data.var_index] : '0;
    assign mag      = (i_data.sample_value >= m_rd) ? i_data.sample_value - m_rd
                                                    : m_rd - i_data.sample_value;

    always_comb begin
        n_sum   = {1'b0, r_sum} + {1'b0, 4'b0, 32'(r_s1_mag) * 32'(r_s1_mag)};
        sum_sat = n_sum[SUM_W] ? '1 : n_sum[SUM_W-1:0];
        if (!r_s1_in_range) begin
            sum_sat = r_sum;
        end
        n_out   = r_outside || (r_s1_in_range && r_s1_out);
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_data.opcode == OP_LOAD && idx_ok) begin
            r_mean  [i_data.var_index] <= i_data.sample_value;
            r_spread[i_data.var_index] <= i_data.spread_in;
            r_lower [i_data.var_index] <= i_data.lower_in;
            r_upper [i_data.var_index] <= i_data.upper_in;
        end
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_sum       <= '0;
            r_outside   <= 1'b0;
            r_vec_valid <= 1'b0;
        end else begin
            if (vec_load) begin
                r_vec_valid <= 1'b1;
            end else if (!i_vec_stall) begin
                r_vec_valid <= 1'b0;
            end
            if (!s1_stall) begin
                if (r_s1_valid) begin
                    if (r_s1_last) begin
                        r_vec.square_sum <= sum_sat;
                        r_vec.outside    <= n_out;
                        r_sum            <= '0;
                        r_outside        <= 1'b0;
                    end else begin
                        r_sum     <= sum_sat;
                        r_outside <= n_out;
                    end
                end
                r_s1_valid <= accept && i_data.opcode == OP_EVAL;
                r_s1_last  <= i_data.last_element;
                r_s1_in_range <= idx_ok;
                r_s1_mag   <= mag;
                r_s1_out   <= idx_ok && (
                    i_data.sample_value < r_lower[i_data.var_index] ||
                    i_data.sample_value > r_upper[i_data.var_index] ||
                    17'(mag) > r_spread[i_data.var_index]);
            end
        end
    end

    assign o_vec_valid = r_vec_valid;
    assign o_vec       = r_vec;

endmodule

[rtl/core/eds_fifo.sv]
// Two-entry queue between the front and back parts.
// Depends on eds_pkg.
module eds_fifo import eds_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_vec_req i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vec_req o_data
);

    t_vec_req r_mem[2];
    logic     r_wp;
    logic     r_rp;
    logic [1:0] r_cnt;
    logic     push;
    logic     pop;

    assign o_stall = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/core/eds_back.sv]
// Back part: square root then division, one bit per cycle each, and the
// output register. Depends on eds_pkg.
module eds_back import eds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIST_W-1:0] i_max_distance,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_vec_req          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_req          o_data
);

    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIV, S_DONE} t_state;

    t_state             r_state;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_val;
    logic [ROOT_W-1:0]  r_root;
    logic [QUO_W-1:0]   r_quo;
    logic [DIST_W:0]    r_prem;
    logic [5:0]         r_cnt;
    logic               r_inside;
    logic               r_out_valid;
    t_out_req           r_out;

    logic [SUM_W+1:0]   trial_rem;
    logic [SUM_W+1:0]   trial_sub;
    logic [DIST_W+1:0]  dshift;
    logic [QUO_W-1:0]   dividend;
    logic [16:0]        score;

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        trial_rem = {r_rem, r_val[SUM_W-1 -: 2]};
        trial_sub = {18'b0, r_root, 2'b01};
        dividend  = {r_root, 18'b0} >> 2;
        dshift    = {r_prem, dividend[6'(QUO_W-1) - r_cnt]};
        score     = 17'h10000 - 17'(r_quo);
        if (r_quo >= QUO_W'(17'h10000)) begin
            score = '0;
        end else if (score[16]) begin
            score = 17'h0FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_val    <= i_data.square_sum;
                        r_rem    <= '0;
                        r_root   <= '0;
                        r_cnt    <= '0;
                        r_inside <= !i_data.outside;
                        r_state  <= (i_data.outside || i_max_distance == '0) ? S_DONE
                                                                               : S_ROOT;
                        r_quo    <= QUO_W'(17'h10000);
                    end
                end
                S_ROOT: begin
                    r_val <= r_val << 2;
                    if (trial_rem >= trial_sub) begin
                        r_rem  <= SUM_W'(trial_rem - trial_sub);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= SUM_W'(trial_rem);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'(ROOT_W - 1)) begin
                        r_cnt   <= '0;
                        r_prem  <= '0;
                        r_quo   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    // restoring divide of root<<16 by max_distance
                    if (dshift >= {2'b0, i_max_distance}) begin
                        r_prem <= (DIST_W+1)'(dshift - {2'b0, i_max_distance});
                        r_quo  <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_prem <= (DIST_W+1)'(dshift);
                        r_quo  <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'(QUO_W - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.inside_envelope    <= r_inside;
                        r_out.presence_score     <= r_inside ? score[15:0] : '0;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/envelope_distance_score_core.sv]
// Envelope distance score core.
// Input channel i_valid/o_stall carries t_in_req requests: load requests write
// one table row, evaluate requests add one element to the running vector.
// Output channel o_valid/i_stall carries one t_out_req per last element.
// The user must write max_distance via i_cfg_we/i_cfg_wdata only while idle;
// the block does not enforce this. After the last element the vector passes
// the stage 1 register, the vector register and the queue; the back part then
// forms the 18-bit square root and 36-bit quotient, one bit per cycle, and
// loads the output register. The input takes one element per cycle while
// o_stall is low; the back part takes a new vector only once done with the
// last. Outside vectors and a zero max_distance skip both iterations.
// Reset clears the running sum, the queue, the back part and max_distance;
// table rows are undefined until loaded.
// A stalled receiver holds the output; the queue then fills and the front
// stalls the input only when a finished vector cannot be queued.
// Depends on eds_pkg, eds_front, eds_fifo and eds_back.
module envelope_distance_score_core import eds_pkg::*; #(
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_req           i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_req          o_data,
    input  logic              i_cfg_we,
    input  logic [DIST_W-1:0] i_cfg_wdata
);

    logic [DIST_W-1:0] r_max_distance;
    logic     f_valid, f_stall, b_valid, b_stall;
    t_vec_req f_vec, b_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= '0;
        end else if (i_cfg_we) begin
            r_max_distance <= i_cfg_wdata;
        end
    end

    eds_front #(.NUM_VARS(NUM_VARS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_vec_valid(f_valid), .i_vec_stall(f_stall), .o_vec(f_vec)
    );

    eds_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_data(f_vec),
        .o_valid(b_valid), .i_stall(b_stall), .o_data(b_vec)
    );

    eds_back u_back (
        .i_clk, .i_rst_n, .i_max_distance(r_max_distance),
        .i_valid(b_valid), .o_stall(b_stall), .i_data(b_vec),
        .o_valid, .i_stall, .o_data
    );

endmodule

[rtl/core/eds_checker.sv]
// Port-level checker for the envelope distance score core, with its bind.
// Depends on eds_pkg and envelope_distance_score_core_assert.svh.
`include "envelope_distance_score_core_assert.svh"
module eds_checker import eds_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_stall,
    input logic     o_valid,
    input logic     i_stall,
    input t_out_req o_data
);

    `EDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `EDS_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n, o_valid && !o_data.inside_envelope, o_data.presence_score == '0)
    `EDS_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)

endmodule

bind envelope_distance_score_core eds_checker u_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_data
);
